>>> hdl/hbar_pkg.sv
// shared types, constants and defaults of the pixel histogram unit
package hbar_pkg;

	// parameter defaults
	localparam int BINS_DEF       = 256;
	localparam int CHANNELS_DEF   = 3;
	localparam int COUNT_BITS_DEF = 32;

	// fixed field widths
	localparam int OP_W       = 2;
	localparam int CH_W       = 2;
	localparam int PIXEL_W    = 17;
	localparam int BIN_IN_W   = 8;
	localparam int BIN_CMD_W  = 12;
	localparam int HEIGHT_W   = 11;
	localparam int COMB_W     = 10;
	localparam int OUT_CNT_W  = 32;
	localparam int QUOT_W     = 11;
	localparam int ITER_W     = 4;

	localparam logic [PIXEL_W-1:0]  PIXEL_ONE    = 17'd65536;
	localparam logic [HEIGHT_W-1:0] HEIGHT_LIMIT = 11'd1024;
	localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 11'd256;

	// operation codes
	localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
	localparam logic [OP_W-1:0] OP_ADD   = 2'd1;
	localparam logic [OP_W-1:0] OP_READ  = 2'd2;

	// queue size
	localparam int QDEPTH = 2;
	localparam int QPTR_W = 1;
	localparam int QCNT_W = 2;

	typedef enum logic [1:0] {
		CMD_CLEAR,
		CMD_ADD,
		CMD_READ,
		CMD_READ_ZERO
	} cmd_kind_t;

	// one classified item
	typedef struct packed {
		cmd_kind_t             kind;
		logic [CH_W-1:0]       channel;
		logic [BIN_CMD_W-1:0]  bin;
	} cmd_t;

	typedef enum logic [2:0] {
		ST_CLR,
		ST_IDLE,
		ST_ADD_WR,
		ST_RD_MUL,
		ST_RD_PREP,
		ST_RD_DIV,
		ST_DONE
	} back_state_t;

endpackage

>>> hdl/hbar_front.sv
// front end: classifies items and maps pixels to bins
module hbar_front #(
	parameter int BINS     = hbar_pkg::BINS_DEF,
	parameter int CHANNELS = hbar_pkg::CHANNELS_DEF
) (
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [hbar_pkg::OP_W-1:0]     operation,
	input  logic [hbar_pkg::CH_W-1:0]     channel,
	input  logic [hbar_pkg::PIXEL_W-1:0]  pixel,
	input  logic [hbar_pkg::BIN_IN_W-1:0] bin_index,
	input  logic                          q_full,
	output logic                          q_push,
	output hbar_pkg::cmd_t                q_cmd
);
	localparam int BIN_W  = $clog2(BINS);
	localparam int PROD_W = hbar_pkg::PIXEL_W + hbar_pkg::BIN_CMD_W;

	logic [hbar_pkg::PIXEL_W-1:0] q_sat;
	logic [PROD_W-1:0]            bin_prod;
	logic                         ch_ok;
	logic                         bin_ok;
	logic                         accept;

	// pixel to bin: floor(q*(BINS-1)/65536)
	assign q_sat    = (pixel > hbar_pkg::PIXEL_ONE) ? hbar_pkg::PIXEL_ONE : pixel;
	assign bin_prod = PROD_W'(q_sat) * PROD_W'(BINS - 1);

	assign ch_ok  = (32'(channel) < 32'(CHANNELS));
	assign bin_ok = (32'(bin_index) < 32'(BINS));

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;

	// classify
	always_comb begin
		q_push        = 1'b0;
		q_cmd.kind    = hbar_pkg::CMD_CLEAR;
		q_cmd.channel = channel;
		q_cmd.bin     = '0;
		case (operation)
			hbar_pkg::OP_CLEAR: begin
				q_push = accept;
			end
			hbar_pkg::OP_ADD: begin
				q_push     = accept && ch_ok;
				q_cmd.kind = hbar_pkg::CMD_ADD;
				q_cmd.bin  = hbar_pkg::BIN_CMD_W'(bin_prod[16 +: BIN_W]);
			end
			hbar_pkg::OP_READ: begin
				q_push     = accept;
				q_cmd.kind = (ch_ok && bin_ok) ? hbar_pkg::CMD_READ : hbar_pkg::CMD_READ_ZERO;
				q_cmd.bin  = hbar_pkg::BIN_CMD_W'(bin_index);
			end
			default: begin
				q_push = 1'b0;
			end
		endcase
	end
endmodule

>>> hdl/hbar_queue.sv
// two-entry queue between front and back
module hbar_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  hbar_pkg::cmd_t push_cmd,
	output logic           full,
	input  logic           pop,
	output logic           head_valid,
	output hbar_pkg::cmd_t head_cmd
);
	hbar_pkg::cmd_t                 slot_q [hbar_pkg::QDEPTH];
	logic [hbar_pkg::QPTR_W-1:0]    wr_ptr_q;
	logic [hbar_pkg::QPTR_W-1:0]    rd_ptr_q;
	logic [hbar_pkg::QCNT_W-1:0]    cnt_q;
	logic                           do_push;
	logic                           do_pop;

	assign full       = (cnt_q == hbar_pkg::QCNT_W'(hbar_pkg::QDEPTH));
	assign head_valid = (cnt_q != '0);
	assign head_cmd   = slot_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop)      cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (do_push) slot_q[wr_ptr_q] <= push_cmd;
	end
endmodule

>>> hdl/hbar_back.sv
// back end: count memory, peaks, bar height division and result register
module hbar_back #(
	parameter int BINS       = hbar_pkg::BINS_DEF,
	parameter int CHANNELS   = hbar_pkg::CHANNELS_DEF,
	parameter int COUNT_BITS = hbar_pkg::COUNT_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           q_valid,
	input  hbar_pkg::cmd_t                 q_cmd,
	output logic                           q_pop,
	input  logic [hbar_pkg::HEIGHT_W-1:0]  height,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [hbar_pkg::OUT_CNT_W-1:0] bin_count,
	output logic [hbar_pkg::HEIGHT_W-1:0]  mono_height,
	output logic [hbar_pkg::COMB_W-1:0]    combined_height
);
	localparam int DEPTH  = CHANNELS * BINS;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int BIN_W  = $clog2(BINS);
	localparam int CHS_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int PROD_W = COUNT_BITS + hbar_pkg::HEIGHT_W;
	localparam int CW     = (COUNT_BITS > 32) ? COUNT_BITS : 32;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	logic [COUNT_BITS-1:0] mem [DEPTH];
	logic [COUNT_BITS-1:0] rdata_q;
	logic [ADDR_W-1:0]     raddr;
	logic                  we;
	logic [ADDR_W-1:0]     waddr;
	logic [COUNT_BITS-1:0] wdata;

	hbar_pkg::back_state_t state_q, state_d;

	logic [COUNT_BITS-1:0]       peak_q [CHANNELS];
	logic [ADDR_W-1:0]           addr_q;
	logic [ADDR_W-1:0]           clr_addr_q;
	logic [CHS_W-1:0]            ch_q;
	logic [COUNT_BITS-1:0]       cnt_q;
	logic [PROD_W-1:0]           prod_q;
	logic [COUNT_BITS-1:0]       pk_q;
	logic [COUNT_BITS-1:0]       allmax_q;
	logic [PROD_W-1:0]           rem_a_q;
	logic [PROD_W-1:0]           rem_b_q;
	logic [hbar_pkg::QUOT_W-1:0] qa_q;
	logic [hbar_pkg::QUOT_W-1:0] qb_q;
	logic [hbar_pkg::ITER_W-1:0] it_q;
	logic                        out_valid_q;
	logic [hbar_pkg::OUT_CNT_W-1:0] out_cnt_q;
	logic [hbar_pkg::HEIGHT_W-1:0]  out_mono_q;
	logic [hbar_pkg::COMB_W-1:0]    out_comb_q;

	logic [ADDR_W-1:0]     cmd_addr;
	logic [CHS_W-1:0]      cmd_ch;
	logic [COUNT_BITS-1:0] inc;
	logic [COUNT_BITS-1:0] allmax;
	logic [PROD_W-1:0]     div_a;
	logic [PROD_W-1:0]     div_b;
	logic                  ge_a;
	logic                  ge_b;
	logic                  out_free;
	logic [CW-1:0]         cnt_ext;

	assign cmd_ch   = CHS_W'(q_cmd.channel);
	assign cmd_addr = ADDR_W'(ADDR_W'(q_cmd.channel) * ADDR_W'(BINS))
	                + ADDR_W'(q_cmd.bin[BIN_W-1:0]);
	assign inc      = (rdata_q == COUNT_MAX) ? rdata_q : rdata_q + 1'b1;
	assign out_free = !out_valid_q || !out_stall;

	// largest peak over channels, at least one
	always_comb begin
		allmax = COUNT_BITS'(1);
		for (int c = 0; c < CHANNELS; c++) begin
			if (peak_q[c] > allmax) allmax = peak_q[c];
		end
	end

	// shifted divisors for the restoring step
	assign div_a = PROD_W'(pk_q) << it_q;
	assign div_b = PROD_W'(allmax_q) << it_q;
	assign ge_a  = (rem_a_q >= div_a);
	assign ge_b  = (rem_b_q >= div_b);

	// count memory
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= hbar_pkg::ST_CLR;
		else         state_q <= state_d;
	end

	// next state and memory control
	always_comb begin
		state_d = state_q;
		q_pop   = 1'b0;
		raddr   = cmd_addr;
		we      = 1'b0;
		waddr   = addr_q;
		wdata   = inc;
		case (state_q)
			hbar_pkg::ST_CLR: begin
				we    = 1'b1;
				waddr = clr_addr_q;
				wdata = '0;
				if (32'(clr_addr_q) == DEPTH - 1) state_d = hbar_pkg::ST_IDLE;
			end
			hbar_pkg::ST_IDLE: begin
				if (q_valid) begin
					q_pop = 1'b1;
					case (q_cmd.kind)
						hbar_pkg::CMD_CLEAR:     state_d = hbar_pkg::ST_CLR;
						hbar_pkg::CMD_ADD:       state_d = hbar_pkg::ST_ADD_WR;
						hbar_pkg::CMD_READ:      state_d = hbar_pkg::ST_RD_MUL;
						hbar_pkg::CMD_READ_ZERO: state_d = hbar_pkg::ST_DONE;
						default:                 state_d = hbar_pkg::ST_IDLE;
					endcase
				end
			end
			hbar_pkg::ST_ADD_WR: begin
				we      = 1'b1;
				state_d = hbar_pkg::ST_IDLE;
			end
			hbar_pkg::ST_RD_MUL:  state_d = hbar_pkg::ST_RD_PREP;
			hbar_pkg::ST_RD_PREP: state_d = hbar_pkg::ST_RD_DIV;
			hbar_pkg::ST_RD_DIV: begin
				if (it_q == '0) state_d = hbar_pkg::ST_DONE;
			end
			hbar_pkg::ST_DONE: begin
				if (out_free) state_d = hbar_pkg::ST_IDLE;
			end
			default: state_d = hbar_pkg::ST_IDLE;
		endcase
	end

	// control registers: clear sweep, peaks, result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q  <= '0;
			out_valid_q <= 1'b0;
			for (int c = 0; c < CHANNELS; c++) peak_q[c] <= '0;
		end else begin
			if (out_valid_q && !out_stall && state_q != hbar_pkg::ST_DONE)
				out_valid_q <= 1'b0;
			case (state_q)
				hbar_pkg::ST_CLR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
				end
				hbar_pkg::ST_IDLE: begin
					if (q_valid && q_cmd.kind == hbar_pkg::CMD_CLEAR) begin
						clr_addr_q <= '0;
						for (int c = 0; c < CHANNELS; c++) peak_q[c] <= '0;
					end
				end
				hbar_pkg::ST_ADD_WR: begin
					if (inc > peak_q[ch_q]) peak_q[ch_q] <= inc;
				end
				hbar_pkg::ST_DONE: begin
					if (out_free) out_valid_q <= 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	assign cnt_ext = CW'(cnt_q);

	// datapath: product, restoring division, result fields
	always_ff @(posedge clk) begin
		case (state_q)
			hbar_pkg::ST_IDLE: begin
				addr_q <= cmd_addr;
				ch_q   <= cmd_ch;
				cnt_q  <= '0;
				pk_q   <= '0;
				qa_q   <= '0;
				qb_q   <= '0;
			end
			hbar_pkg::ST_RD_MUL: begin
				cnt_q    <= rdata_q;
				prod_q   <= PROD_W'(rdata_q) * PROD_W'(height);
				pk_q     <= peak_q[ch_q];
				allmax_q <= allmax;
			end
			hbar_pkg::ST_RD_PREP: begin
				rem_a_q <= prod_q;
				rem_b_q <= (height == '0) ? '0 : prod_q - PROD_W'(cnt_q);
				it_q    <= hbar_pkg::ITER_W'(hbar_pkg::QUOT_W - 1);
			end
			hbar_pkg::ST_RD_DIV: begin
				if (ge_a) begin
					rem_a_q    <= rem_a_q - div_a;
					qa_q[it_q] <= 1'b1;
				end
				if (ge_b) begin
					rem_b_q    <= rem_b_q - div_b;
					qb_q[it_q] <= 1'b1;
				end
				it_q <= it_q - 1'b1;
			end
			hbar_pkg::ST_DONE: begin
				if (out_free) begin
					out_cnt_q  <= (cnt_ext > CW'(32'hFFFF_FFFF)) ? '1 : cnt_ext[31:0];
					out_mono_q <= (pk_q == '0) ? '0 : qa_q;
					out_comb_q <= qb_q[hbar_pkg::COMB_W-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid       = out_valid_q;
	assign bin_count       = out_cnt_q;
	assign mono_height     = out_mono_q;
	assign combined_height = out_comb_q;
endmodule

>>> hdl/pixel_histogram_with_bar_heights_unit.sv
// per-channel pixel histogram with bar heights
// add: one queue slot plus a memory read and write-back
// read: memory read, multiply, two parallel 11-step restoring divisions, then the output register
// clear: one write per entry of the count memory, CHANNELS*BINS entries (768 by default)
// after reset the same clearing pass runs before the first item is carried out
// reset: counts and peaks zero, bar height 256, queue and output empty
module pixel_histogram_with_bar_heights_unit #(
	parameter int BINS       = hbar_pkg::BINS_DEF,
	parameter int CHANNELS   = hbar_pkg::CHANNELS_DEF,
	parameter int COUNT_BITS = hbar_pkg::COUNT_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [hbar_pkg::OP_W-1:0]      operation,
	input  logic [hbar_pkg::CH_W-1:0]      channel,
	input  logic [hbar_pkg::PIXEL_W-1:0]   pixel,
	input  logic [hbar_pkg::BIN_IN_W-1:0]  bin_index,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [hbar_pkg::OUT_CNT_W-1:0] bin_count,
	output logic [hbar_pkg::HEIGHT_W-1:0]  mono_height,
	output logic [hbar_pkg::COMB_W-1:0]    combined_height,
	input  logic                           bar_height_we,
	input  logic [hbar_pkg::HEIGHT_W-1:0]  bar_height_wdata
);
	logic [hbar_pkg::HEIGHT_W-1:0] bar_height_q;
	logic [hbar_pkg::HEIGHT_W-1:0] height;
	logic                          q_full;
	logic                          q_push;
	hbar_pkg::cmd_t                push_cmd;
	logic                          q_pop;
	logic                          head_valid;
	hbar_pkg::cmd_t                head_cmd;

	// bar height register, clamped on use
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)            bar_height_q <= hbar_pkg::HEIGHT_RESET;
		else if (bar_height_we) bar_height_q <= bar_height_wdata;
	end
	assign height = (bar_height_q > hbar_pkg::HEIGHT_LIMIT) ? hbar_pkg::HEIGHT_LIMIT
	                                                          : bar_height_q;

	// front end
	hbar_front #(
		.BINS     (BINS),
		.CHANNELS (CHANNELS)
	) u_front (
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.operation (operation),
		.channel   (channel),
		.pixel     (pixel),
		.bin_index (bin_index),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_cmd     (push_cmd)
	);

	// queue
	hbar_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_cmd   (push_cmd),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (head_valid),
		.head_cmd   (head_cmd)
	);

	// back end
	hbar_back #(
		.BINS       (BINS),
		.CHANNELS   (CHANNELS),
		.COUNT_BITS (COUNT_BITS)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_valid         (head_valid),
		.q_cmd           (head_cmd),
		.q_pop           (q_pop),
		.height          (height),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.bin_count       (bin_count),
		.mono_height     (mono_height),
		.combined_height (combined_height)
	);

	// own-peak height never exceeds the chart height
	a_mono_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (mono_height <= height))
		else $error("mono height above chart height");

	// an empty bin has no bar
	a_zero_bar: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && bin_count == '0) |-> (mono_height == '0 && combined_height == '0))
		else $error("empty bin with nonzero bar");

	// back end only takes from a non-empty queue
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> head_valid)
		else $error("pop from empty queue");
endmodule
